// ===== design/ttw_pkg.sv =====
package ttw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } ttw_state_t;

    typedef enum logic [1:0] {
        WSRC_CHAR,
        WSRC_BLANK,
        WSRC_COPY
    } ttw_wsrc_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic put_exec;
        logic read_exec;
        logic sweep_scroll;
        logic sweep_clear;
        logic out_load;
    } ttw_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             will_scroll;
        logic             sweep_last;
        logic             out_free;
    } ttw_status_t;

endpackage

// ===== design/ttw_ctrl.sv =====
module ttw_ctrl
    import ttw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  ttw_status_t status,
    output ttw_ctrl_t   ctrl
);

    ttw_state_t state_reg;
    ttw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        ctrl          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (status.cmd)
                    CMD_PUT:
                    begin
                        // A put that scrolls writes its cell (a newline writes none) now and reports later.
                        if (status.will_scroll)
                        begin
                            ctrl.put_exec = 1'b1;
                            state_next    = ST_SCROLL;
                        end
                        else if (status.out_free)
                        begin
                            ctrl.put_exec = 1'b1;
                            ctrl.out_load = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    CMD_READ:
                    begin
                        ctrl.read_exec = 1'b1;
                        state_next     = ST_DONE;
                    end
                    default:
                    begin
                        if (status.out_free)
                        begin
                            ctrl.out_load = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_SCROLL:
            begin
                ctrl.sweep_scroll = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_CLEAR:
            begin
                ctrl.sweep_clear = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ttw_datapath.sv =====
module ttw_datapath
    import ttw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic [CMD_W-1:0]    s_axis_tuser,
    input  logic                cfg_valid,
    input  logic [ATTR_W-1:0]   cfg_data,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tuser,
    input  ttw_ctrl_t           ctrl,
    output ttw_status_t         status
);

    // Screen store, one write and one registered read per cycle.
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] wr_data;

    // Control state.
    logic [ATTR_W-1:0] attr_reg,      attr_next;
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic [COL_W-1:0]  col_reg,       col_next;
    logic [ADDR_W-1:0] base_reg,      base_next;
    logic              wr_en_reg,     wr_en_next;
    logic              out_valid_reg, out_valid_next;

    // Payload.
    logic [CMD_W-1:0]  cmd_reg,          cmd_next;
    logic [CHAR_W-1:0] char_reg,         char_next;
    logic [IDX_W-1:0]  idx_reg,          idx_next;
    logic [ADDR_W-1:0] cnt_reg,          cnt_next;
    logic              scrolled_reg,     scrolled_next;
    logic [ADDR_W-1:0] wr_addr_reg,      wr_addr_next;
    ttw_wsrc_t         wr_src_reg,       wr_src_next;
    logic [CELL_W-1:0] out_value_reg,    out_value_next;
    logic [ROW_W-1:0]  out_row_reg,      out_row_next;
    logic [COL_W-1:0]  out_col_reg,      out_col_next;
    logic              out_scrolled_reg, out_scrolled_next;

    logic col_last;
    logic row_last;
    logic is_newline;
    logic row_adv;
    logic idx_ok;
    logic copy_phase;

    assign col_last   = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last   = (row_reg == ROW_W'(ROWS - 1));
    assign is_newline = (char_reg == CHAR_NEWLINE);
    assign row_adv    = is_newline || col_last;
    assign idx_ok     = (32'(idx_reg) < 32'(CELLS));
    assign copy_phase = (cnt_reg < ADDR_W'(CELLS - COLUMNS));

    assign status.cmd         = cmd_reg;
    assign status.will_scroll = (cmd_reg == CMD_PUT) && row_adv && row_last;
    assign status.sweep_last  = (cnt_reg == ADDR_W'(CELLS - 1));
    assign status.out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        unique case (wr_src_reg)
            WSRC_CHAR:  wr_data = {attr_reg, char_reg};
            WSRC_BLANK: wr_data = {attr_reg, CHAR_SPACE};
            WSRC_COPY:  wr_data = rd_data_reg;
            default:    wr_data = {attr_reg, CHAR_SPACE};
        endcase
    end

    always_comb
    begin
        attr_next         = attr_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        base_next         = base_reg;
        wr_en_next        = 1'b0;
        out_valid_next    = out_valid_reg;
        cmd_next          = cmd_reg;
        char_next         = char_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        scrolled_next     = scrolled_reg;
        wr_addr_next      = wr_addr_reg;
        wr_src_next       = wr_src_reg;
        out_value_next    = out_value_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_scrolled_next = out_scrolled_reg;
        rd_en             = 1'b0;
        rd_addr           = ADDR_W'(idx_reg);

        if (cfg_valid)
        begin
            attr_next = cfg_data;
        end

        if (ctrl.load_item)
        begin
            cmd_next      = s_axis_tuser;
            char_next     = s_axis_tdata[CHAR_W-1:0];
            idx_next      = s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W];
            scrolled_next = 1'b0;
            cnt_next      = '0;
        end

        if (ctrl.put_exec)
        begin
            if (!is_newline)
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = base_reg + ADDR_W'(col_reg);
                wr_src_next  = WSRC_CHAR;
            end
            if (row_adv)
            begin
                col_next = '0;
                if (row_last)
                begin
                    scrolled_next = 1'b1;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + ADDR_W'(COLUMNS);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        if (ctrl.read_exec)
        begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(idx_reg);
        end

        // Scroll: each destination cell takes the cell one row below it, read
        // in the cycle before its write; the bottom row gets blanks.
        if (ctrl.sweep_scroll)
        begin
            wr_en_next   = 1'b1;
            wr_addr_next = cnt_reg;
            cnt_next     = cnt_reg + 1'b1;
            if (copy_phase)
            begin
                rd_en       = 1'b1;
                rd_addr     = ADDR_W'(int'(cnt_reg) + COLUMNS);
                wr_src_next = WSRC_COPY;
            end
            else
            begin
                wr_src_next = WSRC_BLANK;
            end
        end

        if (ctrl.sweep_clear)
        begin
            wr_en_next   = 1'b1;
            wr_addr_next = cnt_reg;
            wr_src_next  = WSRC_BLANK;
            cnt_next     = cnt_reg + 1'b1;
        end

        if (ctrl.out_load)
        begin
            out_value_next    = ((cmd_reg == CMD_READ) && idx_ok) ? rd_data_reg : '0;
            out_row_next      = row_next;
            out_col_next      = col_next;
            out_scrolled_next = scrolled_next;
            out_valid_next    = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            attr_reg      <= attr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            wr_en_reg     <= wr_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        char_reg         <= char_next;
        idx_reg          <= idx_next;
        cnt_reg          <= cnt_next;
        scrolled_reg     <= scrolled_next;
        wr_addr_reg      <= wr_addr_next;
        wr_src_reg       <= wr_src_next;
        out_value_reg    <= out_value_next;
        out_row_reg      <= out_row_next;
        out_col_reg      <= out_col_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_DATA_W - CELL_W - ROW_W - COL_W)'(0),
                            out_col_reg, out_row_reg, out_value_reg};
    assign m_axis_tuser  = out_scrolled_reg;

endmodule

// ===== design/text_terminal_writer.sv =====
// Character-cell text terminal with an 80 x 25 screen of 16-bit cells, each
// holding the attribute byte above the character code.
// Commands arrive on the s_axis stream: tuser carries the command (put, clear
// or read), tdata the character and the cell index. Every accepted transfer
// produces exactly one m_axis transfer with the read cell value, the cursor
// position after the command and a scroll flag. The attribute used for all
// written cells is loaded through the cfg channel, which is always ready.
// The long commands, a clear and a put that scrolls the screen, sweep the
// screen store, which has one write and one read port, one cell per cycle:
// a scroll reads each cell one row down in the cycle before writing it, then
// blanks the bottom row. A new command is accepted only once the result of
// the previous one has been loaded into the output register.
// Reset puts the cursor at row 0, column 0 and the attribute at white on
// black; the screen contents are unknown until the first clear. The result
// sits in an output register, so one further command is accepted while the
// receiver stalls; that command then waits in the block until the register
// is taken, and no new transfer is accepted meanwhile.
module text_terminal_writer
    import ttw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // char_code[7:0], cell_index[18:8], zero pad
    input  logic [CMD_W-1:0]    s_axis_tuser,  // cmd[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // cell_value[15:0], cursor_row[20:16],
                                               // cursor_col[27:21], zero pad
    output logic                m_axis_tuser,  // scrolled
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ATTR_W-1:0]   cfg_data
);

    ttw_ctrl_t   ctrl;
    ttw_status_t status;

    // The attribute register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    ttw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .ctrl          (ctrl)
    );

    ttw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .ctrl          (ctrl),
        .status        (status)
    );

endmodule

// ===== design/ttw_checker.sv =====
module ttw_checker
    import ttw_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tuser
);

    // Commands are taken one at a time, never in consecutive cycles.
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in two consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A scroll leaves the cursor at the start of the bottom row and reads nothing.
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[27:21] == '0) &&
            (m_axis_tdata[20:16] == ROW_W'(ROWS - 1)) &&
            (m_axis_tdata[15:0] == '0))
        else $error("scroll reported with wrong cursor or data");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (int'(m_axis_tdata[27:21]) < COLUMNS) && (int'(m_axis_tdata[20:16]) < ROWS))
        else $error("cursor outside the screen");

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ttw_pkg::*;

    // Command 3 has no meaning in the block; it must be passed over quietly.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0] IDX_MAX    = '1;

    // Length of the one long receiver hold-off used to fill the block.
    localparam int HOLD_CYCLES = 600;

    // The random part runs in phases, each with its own attribute setting.
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    // The slowest correct command is a clear or a scroll, which sweeps every
    // cell, plus a random idle gap on each side. The budget covers every command
    // being that slow, several times over.
    localparam int ITEM_BUDGET = 1200;
    localparam int CYCLE_LIMIT = ITEM_BUDGET * (CELLS + 40) * 4 + HOLD_CYCLES;

    // Field positions in the result tdata.
    localparam int ROW_LSB = CELL_W;
    localparam int COL_LSB = CELL_W + ROW_W;

    // One reply of the terminal as the checker compares it.
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } terminal_reply_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // char_code[7:0], cell_index[18:8], zero pad
    logic [CMD_W-1:0]    s_axis_tuser;   // cmd[1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // cell_value[15:0], cursor_row[20:16],
                                         // cursor_col[27:21], zero pad
    logic                m_axis_tuser;   // scrolled
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ATTR_W-1:0]   cfg_data;

    // Shadow copy of the terminal: screen contents, cursor and attribute.
    logic [CELL_W-1:0] screen_image [CELLS];
    int                shadow_row;
    int                shadow_col;
    logic [ATTR_W-1:0] attr_value;

    // Replies still owed by the block, oldest first.
    terminal_reply_t reply_queue [$];

    // When set, neither side idles between transfers.
    bit steady_flow;
    // Asks the receiver to hold off for HOLD_CYCLES after its next transfer.
    bit hold_request;

    int commands_sent;
    int reads_sent;
    int clears_sent;
    int scroll_count;
    int attr_writes;
    int replies_checked;
    int mismatch_count;
    int cycle_count;

    text_terminal_writer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Moves the cursor down one row. Past the bottom row the whole screen
    // moves up, the bottom row is blanked and the cursor goes to column 0.
    function automatic bit shadow_line_feed();
        int i;
        shadow_row++;
        if (shadow_row >= ROWS)
        begin
            shadow_row = ROWS - 1;
            shadow_col = 0;
            for (i = 0; i < CELLS - COLUMNS; i++)
                screen_image[i] = screen_image[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++)
                screen_image[i] = {attr_value, CHAR_SPACE};
            scroll_count++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one command to the shadow terminal and returns the reply that
    // the block must give for it.
    function automatic terminal_reply_t run_terminal_command(
        input logic [CMD_W-1:0]  cmd,
        input logic [CHAR_W-1:0] code,
        input logic [IDX_W-1:0]  cell_index
    );
        terminal_reply_t reply;
        int i;
        reply = '0;
        unique case (cmd)
            CMD_PUT:
            begin
                if (code == CHAR_NEWLINE)
                begin
                    // A newline writes no cell.
                    shadow_col = 0;
                    reply.scrolled = shadow_line_feed();
                end
                else
                begin
                    screen_image[shadow_row * COLUMNS + shadow_col] = {attr_value, code};
                    shadow_col++;
                    if (shadow_col >= COLUMNS)
                    begin
                        shadow_col = 0;
                        reply.scrolled = shadow_line_feed();
                    end
                end
            end
            CMD_CLEAR:
            begin
                // Clearing leaves the cursor where it was.
                for (i = 0; i < CELLS; i++)
                    screen_image[i] = {attr_value, CHAR_SPACE};
            end
            CMD_READ:
            begin
                // Addresses past the end of the screen read as zero.
                if (cell_index < CELLS)
                    reply.cell_value = screen_image[cell_index];
            end
            default:
            begin
            end
        endcase
        reply.cursor_row = ROW_W'(shadow_row);
        reply.cursor_col = COL_W'(shadow_col);
        return reply;
    endfunction

    // Offers one command on the input stream after a random gap and waits
    // for its transfer. The shadow terminal is updated at the transfer edge,
    // so the attribute in use is the one the block holds at that moment.
    // tvalid stays high when the next command follows without a gap.
    task automatic issue_command(
        input logic [CMD_W-1:0]  cmd,
        input logic [CHAR_W-1:0] code,
        input logic [IDX_W-1:0]  cell_index
    );
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - IDX_W - CHAR_W){1'b0}}, cell_index, code};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        reply_queue.push_back(run_terminal_command(cmd, code, cell_index));
        commands_sent++;
        if (cmd == CMD_READ)
            reads_sent++;
        if (cmd == CMD_CLEAR)
            clears_sent++;
    endtask

    // Stops offering commands and waits until every reply has been taken.
    // Each command gives exactly one reply, so the block is idle then.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge clk);
    endtask

    // Writes the attribute register through its own channel.
    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        attr_value = value;
        attr_writes++;
    endtask

    // Runs with the reset attribute: a put and a read back of that cell, the
    // unused command, reads past the end of the screen, then a clear (which
    // must not move the cursor) and a read of the last cell.
    task automatic test_reset_state();
        issue_command(CMD_PUT, 8'h41, '0);
        issue_command(CMD_READ, 8'h00, '0);
        issue_command(CMD_UNUSED, 8'hFF, IDX_MAX);
        issue_command(CMD_READ, 8'h00, IDX_MAX);
        issue_command(CMD_READ, 8'h00, IDX_W'(CELLS));
        issue_command(CMD_CLEAR, 8'h00, '0);
        issue_command(CMD_READ, 8'hFF, IDX_W'(CELLS - 1));
    endtask

    // Writes the all-zero and all-ones character under the all-zero and
    // all-ones attribute, then reads both cells back.
    task automatic test_attribute_extremes();
        wait_idle();
        set_attribute(8'h00);
        issue_command(CMD_PUT, 8'h00, '0);
        wait_idle();
        set_attribute(8'hFF);
        issue_command(CMD_PUT, 8'hFF, IDX_MAX);
        issue_command(CMD_READ, 8'h00, 11'd1);
        issue_command(CMD_READ, 8'h00, 11'd2);
    endtask

    // Walks the cursor down to the bottom row with newlines, marks the bottom
    // row, and scrolls with one more newline. The mark must move up a row and
    // the new bottom row must be blank.
    task automatic test_scroll();
        repeat (ROWS - 1) issue_command(CMD_PUT, CHAR_NEWLINE, '0);
        issue_command(CMD_PUT, 8'h5A, '0);
        issue_command(CMD_PUT, CHAR_NEWLINE, IDX_MAX);
        issue_command(CMD_READ, 8'h00, IDX_W'((ROWS - 2) * COLUMNS));
        issue_command(CMD_READ, 8'h00, IDX_W'((ROWS - 1) * COLUMNS));
    endtask

    // The receiver stops for a long stretch while commands keep coming, so
    // the output register and the waiting command fill and the input stalls.
    task automatic test_back_pressure();
        wait_idle();
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        repeat (12) issue_command(CMD_PUT, CHAR_W'($urandom_range(8'h21, 8'h7E)),
                                  IDX_W'($urandom));
        steady_flow = 1'b0;
    endtask

    // Mostly lines of text of random length and content ended by a newline,
    // some long enough to wrap; mixed with bursts of reads, clears, stray
    // characters and the unused command. Each phase starts with a new
    // attribute, the first two at the extremes.
    task automatic test_random_text();
        int phase;
        int counted;
        int pick;
        int len;
        int k;
        logic [CHAR_W-1:0] code;
        logic [IDX_W-1:0]  cell_index;
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            unique case (phase)
                0: set_attribute(8'hFF);
                1: set_attribute(8'h00);
                default: set_attribute(ATTR_W'($urandom_range(0, 255)));
            endcase
            steady_flow = ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 90)
                                                      : $urandom_range(0, 20);
                    for (k = 0; k < len; k++)
                    begin
                        code = CHAR_W'($urandom_range(0, 255));
                        if (code == CHAR_NEWLINE)
                            code = CHAR_SPACE;
                        issue_command(CMD_PUT, code, IDX_W'($urandom));
                    end
                    counted += len;
                    if ($urandom_range(0, 7) != 0)
                    begin
                        issue_command(CMD_PUT, CHAR_NEWLINE, IDX_W'($urandom));
                        counted++;
                    end
                end
                else if (pick < 15)
                begin
                    len = $urandom_range(1, 8);
                    for (k = 0; k < len; k++)
                    begin
                        // One read in eight goes past the end of the screen.
                        cell_index = ($urandom_range(0, 7) == 0)
                                   ? IDX_W'($urandom_range(CELLS, IDX_MAX))
                                   : IDX_W'($urandom_range(0, CELLS - 1));
                        issue_command(CMD_READ, CHAR_W'($urandom), cell_index);
                    end
                    counted += len;
                end
                else if (pick == 15)
                begin
                    issue_command(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
                    counted++;
                end
                else if (pick == 16)
                begin
                    // Ignored by the block, so it does not count.
                    issue_command(CMD_UNUSED, CHAR_W'($urandom), IDX_W'($urandom));
                end
                else
                begin
                    len = $urandom_range(1, 4);
                    for (k = 0; k < len; k++)
                        issue_command(CMD_PUT, CHAR_W'($urandom_range(0, 255)),
                                      IDX_W'($urandom));
                    counted += len;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // Compares one field of a reply and reports a difference.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every result transfer is checked against the oldest reply owed.
    always @(posedge clk)
    begin : reply_check
        terminal_reply_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            replies_checked++;
            if (reply_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = reply_queue.pop_front();
                check_field("cell_value", 32'(want.cell_value),
                            32'(m_axis_tdata[CELL_W-1:0]));
                check_field("cursor_row", 32'(want.cursor_row),
                            32'(m_axis_tdata[ROW_LSB +: ROW_W]));
                check_field("cursor_col", 32'(want.cursor_col),
                            32'(m_axis_tdata[COL_LSB +: COL_W]));
                check_field("scrolled", 32'(want.scrolled), 32'(m_axis_tuser));
            end
        end
    end

    // Receiver: waits a random number of cycles before each transfer and
    // carries out the long hold-off when one is requested.
    initial
    begin : receiver
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = steady_flow ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // Guard against a block that stops answering.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d replies outstanding.",
                     cycle_count, reply_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_PUT;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        steady_flow   = 1'b0;
        hold_request  = 1'b0;

        // Shadow state after reset. The screen itself is unknown in the block
        // until the first clear, so no cell is read before it is written.
        for (i = 0; i < CELLS; i++)
            screen_image[i] = '0;
        shadow_row = 0;
        shadow_col = 0;
        attr_value = ATTR_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_attribute_extremes();
        test_scroll();
        test_back_pressure();
        test_random_text();

        // Let the last replies drain, then allow one more full sweep of the
        // screen for anything the block might still send.
        wait_idle();
        repeat (CELLS + 16) @(posedge clk);

        $display("Run covered %0d commands: %0d reads, %0d clears, %0d scrolls,",
                 commands_sent, reads_sent, clears_sent, scroll_count);
        $display("%0d attribute writes; checked %0d replies, found %0d mismatches.",
                 attr_writes, replies_checked, mismatch_count);
        if (mismatch_count == 0 && reply_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
